@@ rtl/core/sortpq_pkg.sv @@
// Types, codes and defaults shared by the sorted priority queue modules.
package sortpq_pkg;

  // Default queue depth
  localparam int DEPTH_DEF = 8;

  // Field widths
  localparam int PRIO_W  = 4;
  localparam int CTIME_W = 3;
  localparam int JOBNO_W = 17;
  localparam int PRODN_W = 8;
  localparam int TAG_W   = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 4;

  // Operation codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // One command transfer
  typedef struct packed {
    logic               kind;
    logic [PRIO_W-1:0]  job_priority;
    logic [CTIME_W-1:0] job_compute_time;
    logic [JOBNO_W-1:0] job_number;
    logic [PRODN_W-1:0] producer_number;
    logic [TAG_W-1:0]   producer_tag;
  } job_in_t;

  // One result transfer
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PRIO_W-1:0]  out_priority;
    logic [CTIME_W-1:0] out_compute_time;
    logic [JOBNO_W-1:0] out_job_number;
    logic [PRODN_W-1:0] out_producer_number;
    logic [TAG_W-1:0]   out_producer_tag;
    logic [OCC_W-1:0]   occupancy;
  } job_out_t;

  // One stored job
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [CTIME_W-1:0] ctime;
    logic [JOBNO_W-1:0] job_number;
    logic [PRODN_W-1:0] producer_number;
    logic [TAG_W-1:0]   producer_tag;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming command
    logic exec;   // apply the captured command to the queue
  } ctrl_cmd_t;

endpackage

@@ rtl/core/sortpq_ctrl.sv @@
// Controller state machine of the sorted priority queue.
module sortpq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  output sortpq_pkg::ctrl_cmd_t ctrl
);
  import sortpq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Decode next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state and raise the result strobe after execution
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  // Drive commands to the datapath
  assign busy      = (state != ST_IDLE);
  assign ctrl.load = start && (state == ST_IDLE);
  assign ctrl.exec = (state == ST_EXEC);

endmodule

@@ rtl/core/sortpq_datapath.sv @@
// Datapath of the sorted priority queue: command register, sorted cells, result register.
module sortpq_datapath #(
  parameter int DEPTH = sortpq_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sortpq_pkg::ctrl_cmd_t ctrl,
  input  sortpq_pkg::job_in_t   cmd,
  output sortpq_pkg::job_out_t  result
);
  import sortpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  job_in_t          req;
  entry_t           cells      [DEPTH];
  entry_t           cells_next [DEPTH];
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  job_out_t         res_next;
  entry_t           new_job;
  logic [DEPTH-1:0] ge;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;

  // Hold the command until it is executed
  always_ff @(posedge clk) begin
    if (ctrl.load) req <= cmd;
  end

  assign new_job = '{prio:            req.job_priority,
                     ctime:           req.job_compute_time,
                     job_number:      req.job_number,
                     producer_number: req.producer_number,
                     producer_tag:    req.producer_tag};

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = (req.kind == KIND_PUSH) && !full;
  assign do_pop  = (req.kind == KIND_POP) && !empty;

  // Cells hold jobs in descending priority, head in cell 0; a new job goes
  // behind every stored job of equal or higher priority
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign ge[i] = (count > CW'(i)) && (cells[i].prio >= req.job_priority);

      always_comb begin
        cells_next[i] = cells[i];
        if (do_push && !ge[i]) begin
          if (i == 0) begin
            cells_next[i] = new_job;
          end else if (ge[(i > 0) ? i - 1 : 0]) begin
            cells_next[i] = new_job;
          end else begin
            cells_next[i] = cells[(i > 0) ? i - 1 : 0];
          end
        end else if (do_pop && (i < DEPTH - 1)) begin
          cells_next[i] = cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end

      always_ff @(posedge clk) begin
        if (ctrl.exec) cells[i] <= cells_next[i];
      end
    end
  endgenerate

  // Work out the new count and the result
  always_comb begin
    count_next = count;
    if (do_push) count_next = count + CW'(1);
    else if (do_pop) count_next = count - CW'(1);

    res_next = '0;
    if (req.kind == KIND_PUSH) begin
      res_next.status = full ? STATUS_FULL : STATUS_OK;
    end else if (empty) begin
      res_next.status = STATUS_EMPTY;
    end else begin
      res_next.status              = STATUS_OK;
      res_next.out_priority        = cells[0].prio;
      res_next.out_compute_time    = cells[0].ctime;
      res_next.out_job_number      = cells[0].job_number;
      res_next.out_producer_number = cells[0].producer_number;
      res_next.out_producer_tag    = cells[0].producer_tag;
    end
    res_next.occupancy = OCC_W'(count_next);
  end

  // Update count and result on execution
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) result <= res_next;
  end

endmodule

@@ rtl/core/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: controller plus datapath.
//
// Usage:
//   Command channel: drive cmd and raise start; the transfer happens at the
//   rising edge where start is high and busy is low. cmd.kind selects a push
//   (store the job) or a pop (return the highest-priority job, oldest first
//   among equal priorities).
//   Result channel: done is high for exactly one cycle and result holds the
//   status, the popped job (zeros for a push or an empty pop) and the
//   occupancy after the operation. The transfer happens at the edge ending
//   that cycle; the receiver cannot stall it, so it must sample then.
//   Order: the command transfer loads the command register; the cell row,
//   the count and the result register then update, and done rises with them.
//   Busy is high for the cycle in which the captured command shifts the cell
//   row, so no new command is taken then; a new command may be
//   transferred in the same cycle that done is high.
//   Reset (rst, synchronous, active high): the queue is empty, busy and done
//   are low. Stored job contents are not cleared.
module sorted_priority_queue_core #(
  parameter int DEPTH = sortpq_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sortpq_pkg::job_in_t  cmd,
  output logic                 done,
  output sortpq_pkg::job_out_t result
);
  import sortpq_pkg::*;

  ctrl_cmd_t ctrl;

  // Sequence each command
  sortpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  // Hold the sorted jobs
  sortpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cmd    (cmd),
    .result (result)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 100ps

module tb;
  import sortpq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1650;
  localparam int MAX_REPORTS = 40;

  // One pending command with the idle time that goes before it
  typedef struct {
    job_in_t     cmd;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  job_in_t  cmd = '0;
  logic     busy;
  logic     done;
  job_out_t result;

  stim_t       pending_cmds[$];
  job_out_t    due_results[$];
  entry_t      shadow_jobs[QDEPTH];
  int          shadow_fill = 0;
  int unsigned mismatches = 0;
  logic        took = 1'b0;

  // Driver-private state
  stim_t       nxt;
  bit          have_nxt = 1'b0;
  int unsigned gap_left = 0;

  sorted_priority_queue_core #(.DEPTH(QDEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial forever #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Apply one command to the shadow queue and return the result it yields
  function automatic job_out_t shadow_queue_step(job_in_t c);
    job_out_t r;
    entry_t   e;
    int       pos;
    int       j;
    r = '0;
    if (c.kind == KIND_PUSH) begin
      if (shadow_fill >= QDEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        e = {c.job_priority, c.job_compute_time, c.job_number,
             c.producer_number, c.producer_tag};
        // insert before the first job whose priority is not lower
        pos = 0;
        while (pos < shadow_fill && shadow_jobs[pos].prio < e.prio) pos++;
        for (j = shadow_fill; j > pos; j--) shadow_jobs[j] = shadow_jobs[j-1];
        shadow_jobs[pos] = e;
        shadow_fill++;
        r.status = STATUS_OK;
      end
    end else begin
      if (shadow_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        shadow_fill--;
        e = shadow_jobs[shadow_fill];
        r.status              = STATUS_OK;
        r.out_priority        = e.prio;
        r.out_compute_time    = e.ctime;
        r.out_job_number      = e.job_number;
        r.out_producer_number = e.producer_number;
        r.out_producer_tag    = e.producer_tag;
      end
    end
    r.occupancy = OCC_W'(shadow_fill);
    return r;
  endfunction

  function automatic void queue_cmd(logic kind, logic [PRIO_W-1:0] prio,
                                    logic [CTIME_W-1:0] ct, logic [JOBNO_W-1:0] jn,
                                    logic [PRODN_W-1:0] pn, logic [TAG_W-1:0] tag);
    stim_t s;
    s.cmd   = {kind, prio, ct, jn, pn, tag};
    s.gap   = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    s.drain = 1'b0;
    pending_cmds.push_back(s);
  endfunction

  // Drive commands at the falling edge; hold each one until its transfer
  always @(negedge clk) begin
    if (!rst && !(start && !took)) begin
      if (!have_nxt && pending_cmds.size() != 0) begin
        nxt      = pending_cmds.pop_front();
        have_nxt = 1'b1;
        gap_left = nxt.gap;
      end
      if (have_nxt && gap_left == 0 && !(nxt.drain && due_results.size() != 0)) begin
        cmd      <= nxt.cmd;
        start    <= 1'b1;
        have_nxt = 1'b0;
      end else begin
        if (gap_left != 0) gap_left--;
        start <= 1'b0;
      end
    end
  end

  // Check each result transfer, then predict any command transfer
  always @(posedge clk) begin
    job_out_t want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          flag_mismatch("result with nothing outstanding");
        end else begin
          want = due_results.pop_front();
          cmp_field("status", 32'(result.status), 32'(want.status));
          cmp_field("out_priority", 32'(result.out_priority), 32'(want.out_priority));
          cmp_field("out_compute_time", 32'(result.out_compute_time),
                    32'(want.out_compute_time));
          cmp_field("out_job_number", 32'(result.out_job_number),
                    32'(want.out_job_number));
          cmp_field("out_producer_number", 32'(result.out_producer_number),
                    32'(want.out_producer_number));
          cmp_field("out_producer_tag", result.out_producer_tag, want.out_producer_tag);
          cmp_field("occupancy", 32'(result.occupancy), 32'(want.occupancy));
        end
      end
      if (start && !busy) due_results.push_back(shadow_queue_step(cmd));
      took <= start && !busy;
    end
  end

  // Build the stimulus, release reset, then wait for the queue to drain
  initial begin
    int          seg_left;
    int unsigned push_pct;
    bit          no_gaps;
    stim_t       s;
    logic [PRIO_W-1:0] p;

    // Directed: empty pop, field extremes, ties, full push, drain and empty pop
    queue_cmd(KIND_POP,  4'd0,  3'd0, 17'd0,       8'd0,   32'd0);
    queue_cmd(KIND_PUSH, 4'd10, 3'd4, 17'd100000,  8'd255, 32'hFFFF_FFFF);
    queue_cmd(KIND_PUSH, 4'd1,  3'd1, 17'd1,       8'd0,   32'd0);
    queue_cmd(KIND_PUSH, 4'd0,  3'd0, 17'd0,       8'd0,   32'd0);
    queue_cmd(KIND_PUSH, 4'd15, 3'd7, 17'h1FFFF,   8'hFF,  32'hFFFF_FFFF);
    queue_cmd(KIND_PUSH, 4'd5,  3'd2, 17'd11,      8'd1,   32'h1111_1111);
    queue_cmd(KIND_PUSH, 4'd5,  3'd3, 17'd12,      8'd2,   32'h2222_2222);
    queue_cmd(KIND_PUSH, 4'd5,  3'd4, 17'd13,      8'd3,   32'h3333_3333);
    queue_cmd(KIND_PUSH, 4'd10, 3'd1, 17'd14,      8'd4,   32'h4444_4444);
    queue_cmd(KIND_PUSH, 4'd7,  3'd5, 17'd15,      8'd5,   32'h5555_5555);
    repeat (QDEPTH + 1)
      queue_cmd(KIND_POP, 4'hF, 3'h7, 17'h1FFFF, 8'hFF, 32'hFFFF_FFFF);
    queue_cmd(KIND_PUSH, 4'd3, 3'd2, 17'd77, 8'd9, 32'hDEAD_BEEF);
    queue_cmd(KIND_POP,  4'd0, 3'd0, 17'd0,  8'd0, 32'd0);

    // Random: segments with their own push mix and idling style
    seg_left = 0;
    push_pct = 50;
    no_gaps  = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 3))
          0:       push_pct = 20;
          1:       push_pct = 80;
          default: push_pct = 50;
        endcase
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      seg_left--;
      p = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(1, 10));
      s.cmd.kind             = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
      s.cmd.job_priority     = p;
      s.cmd.job_compute_time = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                           : 3'($urandom_range(1, 4));
      s.cmd.job_number       = ($urandom_range(0, 3) == 0)
                               ? 17'($urandom_range(0, 17'h1FFFF))
                               : 17'($urandom_range(1, 100000));
      s.cmd.producer_number  = 8'($urandom_range(0, 255));
      s.cmd.producer_tag     = $urandom;
      // mostly back to back, a few short gaps, now and then a long one
      if (no_gaps)
        s.gap = 0;
      else if ($urandom_range(0, 9) < 6)
        s.gap = 0;
      else if ($urandom_range(0, 9) < 9)
        s.gap = $urandom_range(1, 3);
      else
        s.gap = $urandom_range(8, 30);
      // hold off until every outstanding result has come back
      s.drain = (i == 0) || ($urandom_range(0, 99) == 0);
      pending_cmds.push_back(s);
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || have_nxt || start) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sortpq_pkg.sv
rtl/core/sortpq_ctrl.sv
rtl/core/sortpq_datapath.sv
rtl/core/sorted_priority_queue_core.sv
bench/tb.sv
